// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro checks a property on the rising
// edge of the given clock and is switched off while the given active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst_n, prop)

`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

// File: sv/mlfq_pkg.sv
`timescale 1ns / 1ps

package mlfq_pkg;

  localparam int FIFO_DEPTH  = 16;
  localparam int NUM_LEVELS  = 4;

  localparam int ID_W        = 8;
  localparam int LEVEL_W     = 3;
  localparam int OUTC_W      = 2;
  localparam int EVENT_W     = 3;
  localparam int QUANT_W     = 8;
  localparam int NUM_QUANTA  = 4;
  localparam int QIDX_W      = 2;

  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_LEVELS * FIFO_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [OUTC_W-1:0] OC_BLOCKED    = 2'd1;
  localparam logic [OUTC_W-1:0] OC_TERMINATED = 2'd2;

  localparam logic [QUANT_W-1:0] QUANT_RESET [NUM_QUANTA] = '{8'd1, 8'd2, 8'd4, 8'd8};

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE       = 3'd0,
    EV_DEMOTED    = 3'd1,
    EV_BLOCKED    = 3'd2,
    EV_TERMINATED = 3'd3,
    EV_ADMITTED   = 3'd4,
    EV_DROPPED    = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  typedef struct packed {
    logic latch;
    logic pop;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } dp_stat_t;

endpackage

// File: sv/mlfq_ram.sv
`timescale 1ns / 1ps

module mlfq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mlfq_ctrl.sv
`timescale 1ns / 1ps

module mlfq_ctrl import mlfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     cmd_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output ctl_cmd_t ctl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    ctl_o     = '0;
    ctl_o.latch = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // A tick with nothing running and a non-empty queue first fetches a queue head.
          if (cmd_i == CMD_TICK && !stat_i.busy && stat_i.ready) begin
            state_d = S_POP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_POP: begin
        ctl_o.pop = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.exec) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/mlfq_dp.sv
`timescale 1ns / 1ps

module mlfq_dp import mlfq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            ctl_i,
  output dp_stat_t            stat_o,
  input  logic                cmd_i,
  input  logic [ID_W-1:0]     proc_id_i,
  input  logic [LEVEL_W-1:0]  admit_level_i,
  input  logic [OUTC_W-1:0]   tick_outcome_i,
  input  logic                cfg_we_i,
  input  logic [QIDX_W-1:0]   cfg_index_i,
  input  logic [QUANT_W-1:0]  cfg_wdata_i,
  output logic                ram_we_o,
  output logic [ADDR_W-1:0]   ram_waddr_o,
  output logic [ID_W-1:0]     ram_wdata_o,
  output logic [ADDR_W-1:0]   ram_raddr_o,
  input  logic [ID_W-1:0]     ram_rdata_i,
  output logic                ran_valid_o,
  output logic [ID_W-1:0]     ran_id_o,
  output logic [LEVEL_W-1:0]  ran_level_o,
  output logic [EVENT_W-1:0]  event_res_o
);

  localparam int SUM_W = PTR_W + 1;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                input logic [PTR_W-1:0] pos);
    return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(pos));
  endfunction

  // Queue bookkeeping and the running process.
  logic [PTR_W-1:0]   heads_q  [NUM_LEVELS];
  logic [CNT_W-1:0]   counts_q [NUM_LEVELS];
  logic [QUANT_W-1:0] quant_q  [NUM_QUANTA];
  logic [ID_W-1:0]    cur_id_q;
  logic [LVL_W-1:0]   cur_lvl_q, cur_lvl_d;
  logic [QUANT_W-1:0] slice_q, slice_d;
  logic               busy_q, busy_d;

  // Latched input beat.
  logic               cmd_q;
  logic [ID_W-1:0]    pid_q;
  logic [LEVEL_W-1:0] alvl_q;
  logic [OUTC_W-1:0]  outc_q;

  // Result register.
  logic               ran_valid_q;
  logic [ID_W-1:0]    ran_id_q;
  logic [LEVEL_W-1:0] ran_level_q;
  event_e             event_q, event_d;

  logic [LVL_W-1:0]   sel_lvl;
  logic               ready;
  logic [PTR_W-1:0]   head_inc;

  logic [QUANT_W-1:0] slice_inc;
  logic [QIDX_W-1:0]  qidx;
  logic               expired;
  logic [LVL_W-1:0]   demote_lvl;
  logic [LVL_W-1:0]   admit_lvl;
  logic               run;
  logic               want_push;
  logic [LVL_W-1:0]   push_lvl;
  logic [ID_W-1:0]    push_id;
  logic               full;
  logic [SUM_W-1:0]   pos_sum;
  logic [PTR_W-1:0]   push_pos;
  logic               push_ok;

  // Highest non-empty level; level index 0 is the highest priority.
  always_comb begin
    sel_lvl = '0;
    ready   = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (counts_q[i] != '0) begin
        sel_lvl = LVL_W'(i);
        ready   = 1'b1;
      end
    end
  end

  assign head_inc = (heads_q[sel_lvl] == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                  : heads_q[sel_lvl] + 1'b1;

  always_comb begin
    slice_inc  = slice_q + 1'b1;
    qidx       = (32'(cur_lvl_q) >= NUM_QUANTA - 1) ? QIDX_W'(NUM_QUANTA - 1)
                                                     : QIDX_W'(cur_lvl_q);
    expired    = (slice_inc >= quant_q[qidx]);
    demote_lvl = (cur_lvl_q == LVL_W'(NUM_LEVELS - 1)) ? cur_lvl_q : cur_lvl_q + 1'b1;

    if (alvl_q == '0) begin
      admit_lvl = '0;
    end else if (32'(alvl_q) > NUM_LEVELS) begin
      admit_lvl = LVL_W'(NUM_LEVELS - 1);
    end else begin
      admit_lvl = LVL_W'(alvl_q - 1'b1);
    end

    run       = (cmd_q == CMD_TICK) && busy_q;
    want_push = 1'b0;
    push_lvl  = admit_lvl;
    push_id   = pid_q;
    if (cmd_q == CMD_ADMIT) begin
      want_push = 1'b1;
    end else if (run && outc_q != OC_BLOCKED && outc_q != OC_TERMINATED && expired) begin
      want_push = 1'b1;
      push_lvl  = demote_lvl;
      push_id   = cur_id_q;
    end

    full     = (counts_q[push_lvl] == CNT_W'(FIFO_DEPTH));
    pos_sum  = {1'b0, heads_q[push_lvl]} + SUM_W'(counts_q[push_lvl]);
    push_pos = (pos_sum >= SUM_W'(FIFO_DEPTH)) ? PTR_W'(pos_sum - SUM_W'(FIFO_DEPTH))
                                               : PTR_W'(pos_sum);
    push_ok  = want_push && !full;

    event_d   = EV_NONE;
    busy_d    = busy_q;
    cur_lvl_d = cur_lvl_q;
    slice_d   = slice_q;
    if (cmd_q == CMD_ADMIT) begin
      event_d = push_ok ? EV_ADMITTED : EV_DROPPED;
    end else if (run) begin
      slice_d = slice_inc;
      case (outc_q)
        OC_BLOCKED: begin
          busy_d  = 1'b0;
          event_d = EV_BLOCKED;
        end
        OC_TERMINATED: begin
          busy_d  = 1'b0;
          event_d = EV_TERMINATED;
        end
        default: begin
          if (expired) begin
            // A demoted process that finds its new queue full keeps running.
            cur_lvl_d = demote_lvl;
            slice_d   = '0;
            if (push_ok) begin
              busy_d  = 1'b0;
              event_d = EV_DEMOTED;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        heads_q[i]  <= '0;
        counts_q[i] <= '0;
      end
      for (int i = 0; i < NUM_QUANTA; i++) begin
        quant_q[i] <= QUANT_RESET[i];
      end
      cur_id_q  <= '0;
      cur_lvl_q <= '0;
      slice_q   <= '0;
      busy_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quant_q[cfg_index_i] <= cfg_wdata_i;
      end
      if (ctl_i.pop) begin
        heads_q[sel_lvl]  <= head_inc;
        counts_q[sel_lvl] <= counts_q[sel_lvl] - 1'b1;
        // A dummy id is dropped from the queue and never becomes current.
        if (ram_rdata_i != '0) begin
          cur_id_q  <= ram_rdata_i;
          cur_lvl_q <= sel_lvl;
          slice_q   <= '0;
          busy_q    <= 1'b1;
        end
      end
      if (ctl_i.exec) begin
        if (push_ok) begin
          counts_q[push_lvl] <= counts_q[push_lvl] + 1'b1;
        end
        busy_q    <= busy_d;
        cur_lvl_q <= cur_lvl_d;
        slice_q   <= slice_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q  <= cmd_i;
      pid_q  <= proc_id_i;
      alvl_q <= admit_level_i;
      outc_q <= tick_outcome_i;
    end
    if (ctl_i.exec) begin
      ran_valid_q <= run;
      ran_id_q    <= run ? cur_id_q : '0;
      ran_level_q <= run ? LEVEL_W'({1'b0, cur_lvl_q}) + LEVEL_W'(1) : '0;
      event_q     <= event_d;
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.ready = ready;

  assign ram_we_o    = ctl_i.exec && push_ok;
  assign ram_waddr_o = addr_of(push_lvl, push_pos);
  assign ram_wdata_o = push_id;
  assign ram_raddr_o = addr_of(sel_lvl, heads_q[sel_lvl]);

  assign ran_valid_o = ran_valid_q;
  assign ran_id_o    = ran_id_q;
  assign ran_level_o = ran_level_q;
  assign event_res_o = event_q;

endmodule

// File: sv/mlfq_four_level_scheduler.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Four-level feedback queue scheduler. Each input beat is either an admit, which
// queues a process id at the tail of its level (a full queue drops it), or a tick,
// which runs the current process for one instruction; when no process is current the
// tick first takes the head of the highest non-empty level, and a dummy id of zero is
// discarded without running anything. Blocked or terminated processes leave; a
// process that uses up its level's quantum drops one level (or stays at the lowest)
// and is queued again, or keeps running if that queue is full. Every input beat yields
// exactly one result beat. An admit, or a tick with a process running or none queued,
// goes from the accepting cycle to the execute state, where its result register is
// loaded once the output register is free; a tick needing a queue head first passes
// through a pop state for the registered read of the shared id store. The input side
// is taken again as soon as the result is registered, so a result waiting on a stalled
// output does not block the next acceptance, although the following result waits for
// the output register to free. The id store has no reset: only entries that were
// written are ever read. The user must write the four quantum registers through the
// configuration port only while the block is idle; the block does not enforce it.
module mlfq_four_level_scheduler import mlfq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [ID_W-1:0]     proc_id_i,
  input  logic [LEVEL_W-1:0]  admit_level_i,
  input  logic [OUTC_W-1:0]   tick_outcome_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                ran_valid_o,
  output logic [ID_W-1:0]     ran_id_o,
  output logic [LEVEL_W-1:0]  ran_level_o,
  output logic [EVENT_W-1:0]  event_res_o,
  input  logic                cfg_we_i,
  input  logic [QIDX_W-1:0]   cfg_index_i,
  input  logic [QUANT_W-1:0]  cfg_wdata_i
);

  ctl_cmd_t          ctl;
  dp_stat_t          stat;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ID_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ID_W-1:0]   ram_rdata;

  // The controller sequences each beat through a fetch where needed and an execute step
  // and owns the output valid; the datapath holds the queues, running process and result.
  mlfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  mlfq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .proc_id_i      (proc_id_i),
    .admit_level_i  (admit_level_i),
    .tick_outcome_i (tick_outcome_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .ran_valid_o    (ran_valid_o),
    .ran_id_o       (ran_id_o),
    .ran_level_o    (ran_level_o),
    .event_res_o    (event_res_o)
  );

  // All level queues share one store; level l occupies a contiguous block of entries.
  mlfq_ram #(
    .Width (ID_W),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An accepted beat always takes the controller out of the idle state, stalling the input.
  `ASSERT_PROP(a_accept_then_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // A process that ran carries a real level.
  `ASSERT_NEVER(a_ran_has_level, clk_i, rst_ni, out_valid_o && ran_valid_o && ran_level_o == '0)

  // With nothing run, the id and level fields are zero.
  `ASSERT_NEVER(a_idle_fields_zero, clk_i, rst_ni,
                out_valid_o && !ran_valid_o && (ran_id_o != '0 || ran_level_o != '0))

  // Demote, block and terminate events only come with a process that ran.
  `ASSERT_NEVER(a_event_needs_run, clk_i, rst_ni,
                out_valid_o && !ran_valid_o && (event_res_o == EV_DEMOTED ||
                event_res_o == EV_BLOCKED || event_res_o == EV_TERMINATED))

  // The store is never written while a head fetch is in flight.
  `ASSERT_NEVER(a_no_write_on_fetch, clk_i, rst_ni, ctl.pop && ram_we)

endmodule
